### design/plgl_pkg.sv
// ----------------------------------------------------------------------------
// plgl_pkg: shared types and constants for the piecewise-linear gain lookup
// Table geometry, command and region codes, queue item layout, divider sizes.
// ----------------------------------------------------------------------------
package plgl_pkg;

  // Table geometry
  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int VAL_W      = 32;
  localparam int PTS_W      = 6;
  localparam logic [PTS_W-1:0] PTS_RESET = 6'd30;

  // Input command codes
  localparam logic [1:0] CMD_WR_BP   = 2'd0;
  localparam logic [1:0] CMD_WR_GAIN = 2'd1;
  localparam logic [1:0] CMD_EVAL    = 2'd2;

  // Result region codes
  localparam logic [1:0] REG_INTERIOR = 2'd0;
  localparam logic [1:0] REG_LOW      = 2'd1;
  localparam logic [1:0] REG_HIGH     = 2'd2;
  localparam logic [1:0] REG_NONE     = 2'd3;

  // Saturation limits
  localparam logic [VAL_W-1:0] GAIN_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] GAIN_MIN = 32'h8000_0000;

  // Front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Serial divider: 65-bit product over 32-bit span, 33-bit quotient
  localparam int DIVD_W    = 65;
  localparam int DIVS_W    = 32;
  localparam int QUO_W     = 33;
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } q_item_t;

endpackage

### design/piecewise_linear_gain_lookup_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_gain_lookup_top: piecewise-linear gain table lookup
// Breakpoint and gain tables loaded by write beats; evaluate beats return an
// interpolated, saturated Q16.16 gain with a region code.
//
//   channel | direction | tdata                         | tuser
//   in_     | slave     | [4:0] entry, [36:5] value     | [1:0] cmd
//   out_    | master    | [31:0] gain                   | [1:0] region
//   cfg_    | write     | cfg_wr_data[5:0] points_in_use| -
//
// Write beats are written to the tables when popped. A clamped evaluate
// returns after the end-point checks; an interior one also waits for the
// one-entry-per-cycle scan of the breakpoint memory, the multiply and the
// serial divider. Items are processed one at a time; a two-beat queue keeps
// accepting, until full, while the back end works or a result is stalled.
// Synchronous active-low reset; tables are not cleared.
// ----------------------------------------------------------------------------
module piecewise_linear_gain_lookup_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [4:0] entry, [36:5] value, [39:37] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] gain
  output logic [1:0]  out_tuser,  // [1:0] region
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);
  import plgl_pkg::*;

  logic    q_valid, q_ready;
  q_item_t q_item;

  plgl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_entry  (in_tdata[IDX_W-1:0]),
    .in_value  (in_tdata[IDX_W+VAL_W-1:IDX_W]),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  plgl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_gain    (out_tdata),
    .out_region  (out_tuser)
  );

endmodule

### design/plgl_front.sv
// ----------------------------------------------------------------------------
// plgl_front: input acceptance, classification and two-entry queue
// Drops unused commands and out-of-range writes, queues the rest for the back.
// ----------------------------------------------------------------------------
module plgl_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [1:0]                    in_cmd,
  input  logic [plgl_pkg::IDX_W-1:0]    in_entry,
  input  logic [plgl_pkg::VAL_W-1:0]    in_value,
  output logic                          q_valid,
  input  logic                          q_ready,
  output plgl_pkg::q_item_t             q_item
);
  import plgl_pkg::*;

  q_item_t          fifo_mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             accept, keep, push, pop;
  q_item_t          new_item;

  // Classify the incoming beat
  always_comb begin
    keep = 1'b0;
    case (in_cmd)
      CMD_WR_BP, CMD_WR_GAIN: keep = (32'(in_entry) < MAX_POINTS);
      CMD_EVAL:               keep = 1'b1;
      default:                keep = 1'b0;
    endcase
  end

  assign in_tready = (count_r != QCW'(QDEPTH));
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && keep;
  assign q_valid   = (count_r != '0);
  assign pop       = q_valid && q_ready;
  assign q_item    = fifo_mem[rd_ptr_r];

  assign new_item.op    = in_cmd;
  assign new_item.idx   = in_entry;
  assign new_item.value = $signed(in_value);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= new_item;
    end
  end

endmodule

### design/plgl_div.sv
// ----------------------------------------------------------------------------
// plgl_div: restoring divider, one quotient bit per cycle
// Dividend must satisfy dividend < divisor * 2^QUO_W; done pulses with the result.
// ----------------------------------------------------------------------------
module plgl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [plgl_pkg::DIVD_W-1:0]   dividend,
  input  logic [plgl_pkg::DIVS_W-1:0]   divisor,
  output logic                          done,
  output logic [plgl_pkg::QUO_W-1:0]    quotient
);
  import plgl_pkg::*;

  logic [DIVS_W-1:0]    rem_r;
  logic [QUO_W-1:0]     dq_r;
  logic [DIVS_W-1:0]    dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIVS_W:0]      trial;
  logic                 ge;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_r, dq_r[QUO_W-1]};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIVD_W-1:QUO_W];
      dq_r  <= dividend[QUO_W-1:0];
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? DIVS_W'(trial - {1'b0, dsr_r}) : trial[DIVS_W-1:0];
      dq_r  <= {dq_r[QUO_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

### design/plgl_back.sv
// ----------------------------------------------------------------------------
// plgl_back: table storage, interval search, interpolation and result register
// Pops queued items, writes tables or runs the search / multiply / divide.
// ----------------------------------------------------------------------------
module plgl_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [plgl_pkg::PTS_W-1:0]    cfg_wr_data,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  plgl_pkg::q_item_t             q_item,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [plgl_pkg::VAL_W-1:0]    out_gain,
  output logic [1:0]                    out_region
);
  import plgl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LO     = 4'd1;
  localparam logic [3:0] S_HI     = 4'd2;
  localparam logic [3:0] S_SCAN0  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_MUL0   = 4'd5;
  localparam logic [3:0] S_MUL1   = 4'd6;
  localparam logic [3:0] S_MUL2   = 4'd7;
  localparam logic [3:0] S_DSTART = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  // Tables
  logic signed [VAL_W-1:0] bp_mem   [MAX_POINTS];
  logic signed [VAL_W-1:0] gain_mem [MAX_POINTS];
  logic signed [VAL_W-1:0] bp_q, g_q;
  logic [IDX_W-1:0]        rd_addr;

  // Control
  logic [3:0]              state_r, state_nxt;
  logic [PTS_W-1:0]        pts_r;
  logic [IDX_W-1:0]        nlast;
  logic [IDX_W-1:0]        scan_idx_r;
  logic                    pop, wr_bp, wr_gain;
  logic                    out_valid_r, out_free;

  // Evaluation datapath
  logic signed [VAL_W-1:0] x_r, xa_r, ya_r, glast_r;
  logic signed [VAL_W-1:0] res_gain_r;
  logic [1:0]              res_region_r;
  logic [VAL_W-1:0]        span_r, off_r;
  logic [QUO_W-1:0]        mag_r;
  logic                    neg_r;
  logic [QUO_W+15:0]       pp_r;
  logic [DIVD_W-1:0]       prod_r;
  logic [VAL_W-1:0]        out_gain_r;
  logic [1:0]              out_region_r;

  logic                    hit, div_start, div_done;
  logic [QUO_W-1:0]        quot;
  logic signed [QUO_W:0]   dy, sq;
  logic signed [QUO_W+1:0] sum;
  logic [VAL_W-1:0]        sat_gain;

  // Active point count clamped to 1..MAX_POINTS, index of the last point
  always_comb begin
    if (pts_r == '0) begin
      nlast = '0;
    end else if (32'(pts_r) > MAX_POINTS) begin
      nlast = IDX_W'(MAX_POINTS - 1);
    end else begin
      nlast = IDX_W'(pts_r - 1'b1);
    end
  end

  assign q_ready  = (state_r == S_IDLE);
  assign pop      = q_valid && q_ready;
  assign wr_bp    = pop && (q_item.op == CMD_WR_BP);
  assign wr_gain  = pop && (q_item.op == CMD_WR_GAIN);
  assign out_free = !out_valid_r || out_tready;

  // Read address per state; the read data is registered and comes back in the next cycle
  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = '0;
      S_LO:    rd_addr = nlast;
      S_HI:    rd_addr = '0;
      S_SCAN0: rd_addr = IDX_W'(1);
      S_SCAN:  rd_addr = scan_idx_r + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_bp) begin
      bp_mem[q_item.idx] <= q_item.value;
    end
    bp_q <= bp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_gain) begin
      gain_mem[q_item.idx] <= q_item.value;
    end
    g_q <= gain_mem[rd_addr];
  end

  // Bracket test and interpolation operands
  assign hit = (xa_r <= x_r) && (x_r <= bp_q);
  assign dy  = {{2{g_q[VAL_W-1]}}, g_q} - {{2{ya_r[VAL_W-1]}}, ya_r};

  // Signed quotient and saturated sum
  assign sq  = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign sum = {{3{ya_r[VAL_W-1]}}, ya_r} + {sq[QUO_W], sq};
  always_comb begin
    if (sum[QUO_W+1:VAL_W-1] == '0 || sum[QUO_W+1:VAL_W-1] == '1) begin
      sat_gain = sum[VAL_W-1:0];
    end else if (sum[QUO_W+1]) begin
      sat_gain = GAIN_MIN;
    end else begin
      sat_gain = GAIN_MAX;
    end
  end

  assign div_start = (state_r == S_DSTART);

  plgl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (quot)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop && q_item.op == CMD_EVAL) begin
          state_nxt = S_LO;
        end
      end
      S_LO:     state_nxt = (x_r <= bp_q) ? S_OUT : S_HI;
      S_HI:     state_nxt = (x_r >= bp_q) ? S_OUT : S_SCAN0;
      S_SCAN0:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (hit) begin
          state_nxt = (xa_r == bp_q) ? S_OUT : S_MUL0;
        end else if (scan_idx_r == nlast) begin
          state_nxt = S_OUT;
        end
      end
      S_MUL0:   state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DIV;
      S_DIV:    state_nxt = div_done ? S_OUT : S_DIV;
      S_OUT:    state_nxt = out_free ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pts_r       <= PTS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        pts_r <= cfg_wr_data;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Evaluation datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r <= q_item.value;
      end
      S_LO: begin
        res_gain_r   <= g_q;
        res_region_r <= REG_LOW;
      end
      S_HI: begin
        res_gain_r   <= g_q;
        res_region_r <= REG_HIGH;
        glast_r      <= g_q;
      end
      S_SCAN0: begin
        xa_r       <= bp_q;
        ya_r       <= g_q;
        scan_idx_r <= IDX_W'(1);
      end
      S_SCAN: begin
        if (hit) begin
          res_gain_r   <= ya_r;
          res_region_r <= REG_INTERIOR;
          span_r       <= VAL_W'(bp_q - xa_r);
          off_r        <= VAL_W'(x_r - xa_r);
          neg_r        <= dy[QUO_W];
          mag_r        <= dy[QUO_W] ? QUO_W'(-dy) : QUO_W'(dy);
        end else begin
          res_gain_r   <= glast_r;
          res_region_r <= REG_NONE;
          xa_r         <= bp_q;
          ya_r         <= g_q;
          scan_idx_r   <= scan_idx_r + 1'b1;
        end
      end
      S_MUL0: begin
        pp_r <= mag_r * off_r[15:0];
      end
      S_MUL1: begin
        prod_r <= {16'b0, pp_r};
        pp_r   <= mag_r * off_r[VAL_W-1:16];
      end
      S_MUL2: begin
        prod_r <= prod_r + {pp_r, 16'b0};
      end
      S_DIV: begin
        if (div_done) begin
          res_gain_r <= $signed(sat_gain);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_gain_r   <= res_gain_r;
      out_region_r <= res_region_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_gain   = out_gain_r;
  assign out_region = out_region_r;

endmodule

### design/plgl_checker.sv
// ----------------------------------------------------------------------------
// plgl_checker: port-level assertions for the gain lookup
// Output hold under stall, reset behavior and minimum result latency.
// ----------------------------------------------------------------------------
module plgl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Reset empties the queue and the result register
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("queue or result register not cleared by reset");

  // A result needs an evaluate beat and a pass through the queue first
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
    else $error("result appeared too soon after reset");

endmodule

bind piecewise_linear_gain_lookup_top plgl_checker u_chk (.*);
